/* hdl/scp_pkg.sv */
// ----------------------------------------------------------------------------
// scp_pkg: shared types and constants of the setpoint command parser
// Character classes, queue entry, configuration and result records.
// ----------------------------------------------------------------------------
package scp_pkg;

  // number of parsed axes and number of axes shown on the result ports
  localparam int NUM_AXES = 3;
  localparam int OUT_AXES = 3;

  // token counter runs 0 .. NUM_AXES+1
  localparam int TI_W = $clog2(NUM_AXES + 2);
  localparam int AXIS_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  localparam int CHAR_W = 8;
  localparam int VAL_W  = 16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERMINATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND    = 2'd2;

  // reset values of the configuration registers
  localparam logic [CHAR_W-1:0] SEPARATOR_RESET  = 8'd32;
  localparam logic [CHAR_W-1:0] TERMINATOR_RESET = 8'd13;
  localparam logic [CHAR_W-1:0] COMMAND_RESET    = 8'd68;

  // character codes used by the value parser
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;

  // class of one received character
  typedef enum logic [1:0] {
    CLS_CHAR,
    CLS_SEP,
    CLS_TERM
  } cls_t;

  // entry of the command queue
  typedef struct packed {
    cls_t              cls;
    logic [CHAR_W-1:0] ch;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [CHAR_W-1:0] separator;
    logic [CHAR_W-1:0] terminator;
    logic [CHAR_W-1:0] command;
  } cfg_t;

  typedef logic signed [VAL_W-1:0] moment_t;

  // one result transaction
  typedef struct packed {
    logic                       status;
    moment_t [OUT_AXES-1:0]     moment;
  } result_t;

endpackage

/* hdl/scp_front.sv */
// ----------------------------------------------------------------------------
// scp_front: character classifier
// Sorts each accepted character into terminator, separator or token text.
// ----------------------------------------------------------------------------
module scp_front (
  input  logic                      push,
  input  logic                      full,
  input  logic [scp_pkg::CHAR_W-1:0] char_in,
  input  scp_pkg::cfg_t             cfg,
  output logic                      q_write,
  output scp_pkg::item_t            q_item
);

  // accepted character goes straight into the command queue
  assign q_write = push && !full;

  // terminator wins over separator when both codes are equal
  always_comb begin
    q_item.ch = char_in;
    if (char_in == cfg.terminator) begin
      q_item.cls = scp_pkg::CLS_TERM;
    end else if (char_in == cfg.separator) begin
      q_item.cls = scp_pkg::CLS_SEP;
    end else begin
      q_item.cls = scp_pkg::CLS_CHAR;
    end
  end

endmodule

/* hdl/scp_cmd_queue.sv */
// ----------------------------------------------------------------------------
// scp_cmd_queue: short queue of classified characters
// Decouples the classifier from the parser; write and read may happen in the same cycle.
// ----------------------------------------------------------------------------
module scp_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  scp_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd,
  output logic           rd_valid,
  output scp_pkg::item_t rd_item
);

  scp_pkg::item_t                     entries [scp_pkg::QUEUE_DEPTH];
  logic [scp_pkg::QPTR_W-1:0]         wr_ptr;
  logic [scp_pkg::QPTR_W-1:0]         rd_ptr;
  logic [scp_pkg::QCNT_W-1:0]         count;

  assign full     = (count == scp_pkg::QCNT_W'(scp_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

/* hdl/scp_back.sv */
// ----------------------------------------------------------------------------
// scp_back: token parser and setpoint holder
// Builds tokens and values, commits the setpoint on a good line and
// keeps one result in an output register.
// ----------------------------------------------------------------------------
module scp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [scp_pkg::CHAR_W-1:0] command,
  input  logic                       q_valid,
  input  scp_pkg::item_t             q_item,
  output logic                       q_read,
  input  logic                       res_pop,
  output logic                       res_valid,
  output scp_pkg::result_t           res
);

  localparam logic [scp_pkg::TI_W-1:0] TI_LAST = scp_pkg::TI_W'(scp_pkg::NUM_AXES);
  localparam logic [scp_pkg::TI_W-1:0] TI_DONE = scp_pkg::TI_W'(scp_pkg::NUM_AXES + 1);

  // per-line parse state
  logic [scp_pkg::TI_W-1:0]  token_index;
  logic [scp_pkg::TI_W-1:0]  token_index_next;
  logic                      in_token;
  logic                      in_token_next;
  logic [1:0]                char_position;
  logic [1:0]                char_position_next;
  logic                      header_good;
  logic                      header_good_next;
  logic                      negative_flag;
  logic                      negative_flag_next;
  logic [scp_pkg::VAL_W-1:0] accumulator;
  logic [scp_pkg::VAL_W-1:0] accumulator_next;

  logic [scp_pkg::VAL_W-1:0] parsed_values      [scp_pkg::NUM_AXES];
  logic [scp_pkg::VAL_W-1:0] parsed_values_next [scp_pkg::NUM_AXES];
  logic [scp_pkg::VAL_W-1:0] held_setpoint      [scp_pkg::NUM_AXES];
  logic [scp_pkg::VAL_W-1:0] held_setpoint_next [scp_pkg::NUM_AXES];

  // helpers
  logic [1:0]                cp_eff;
  logic [scp_pkg::VAL_W-1:0] acc_eff;
  logic [scp_pkg::VAL_W-1:0] acc_times_ten;
  logic [scp_pkg::VAL_W-1:0] close_value;
  logic [scp_pkg::TI_W-1:0]  close_index;
  logic [scp_pkg::TI_W-1:0]  term_index;
  logic                      line_ok;
  logic                      take;
  logic                      load_result;
  scp_pkg::result_t          res_next;

  // a terminator waits while the output register is still occupied
  assign take = q_valid &&
                ((q_item.cls != scp_pkg::CLS_TERM) || !res_valid || res_pop);
  assign q_read      = take;
  assign load_result = take && (q_item.cls == scp_pkg::CLS_TERM);

  // a new token starts from clean per-token state
  assign cp_eff        = in_token ? char_position : 2'd0;
  assign acc_eff       = in_token ? accumulator : '0;
  assign acc_times_ten = (acc_eff << 3) + (acc_eff << 1);

  // value and token count when the current token closes
  assign close_value = negative_flag ? (~accumulator + 1'b1) : accumulator;
  assign close_index = (token_index <= TI_LAST) ? (token_index + 1'b1) : token_index;
  assign term_index  = in_token ? close_index : token_index;
  assign line_ok     = header_good && (term_index == TI_DONE);

  // parser next state
  always_comb begin
    token_index_next   = token_index;
    in_token_next      = in_token;
    char_position_next = char_position;
    header_good_next   = header_good;
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    parsed_values_next = parsed_values;
    held_setpoint_next = held_setpoint;

    // closing a value token stores it in its axis slot
    if (in_token && (q_item.cls != scp_pkg::CLS_CHAR)) begin
      for (int a = 0; a < scp_pkg::NUM_AXES; a++) begin
        if (token_index == scp_pkg::TI_W'(a + 1)) begin
          parsed_values_next[a] = close_value;
        end
      end
    end

    case (q_item.cls)
      scp_pkg::CLS_CHAR: begin
        in_token_next      = 1'b1;
        negative_flag_next = in_token ? negative_flag : 1'b0;
        accumulator_next   = acc_eff;
        if (token_index == '0) begin
          header_good_next = (cp_eff == 2'd0) && (q_item.ch == command);
        end else if (token_index <= TI_LAST) begin
          if ((cp_eff == 2'd0) && (q_item.ch == scp_pkg::MINUS_CHAR)) begin
            negative_flag_next = 1'b1;
          end else begin
            accumulator_next = acc_times_ten + scp_pkg::VAL_W'(q_item.ch)
                               - scp_pkg::VAL_W'(scp_pkg::ZERO_CHAR);
          end
        end
        char_position_next = (cp_eff == 2'd3) ? 2'd3 : (cp_eff + 2'd1);
      end
      scp_pkg::CLS_SEP: begin
        if (in_token) begin
          token_index_next   = close_index;
          in_token_next      = 1'b0;
          char_position_next = 2'd0;
          negative_flag_next = 1'b0;
          accumulator_next   = '0;
        end
      end
      scp_pkg::CLS_TERM: begin
        if (line_ok) begin
          held_setpoint_next = parsed_values_next;
        end
        token_index_next   = '0;
        in_token_next      = 1'b0;
        char_position_next = 2'd0;
        header_good_next   = 1'b0;
        negative_flag_next = 1'b0;
        accumulator_next   = '0;
      end
      default: begin
        token_index_next = token_index;
      end
    endcase
  end

  // result record for a terminator
  always_comb begin
    res_next.status = !line_ok;
    for (int a = 0; a < scp_pkg::OUT_AXES; a++) begin
      res_next.moment[a] = '0;
      if (a < scp_pkg::NUM_AXES) begin
        res_next.moment[a] = held_setpoint_next[a];
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      token_index   <= '0;
      in_token      <= 1'b0;
      char_position <= 2'd0;
      header_good   <= 1'b0;
      negative_flag <= 1'b0;
      accumulator   <= '0;
      for (int a = 0; a < scp_pkg::NUM_AXES; a++) begin
        held_setpoint[a] <= '0;
      end
    end else if (take) begin
      token_index   <= token_index_next;
      in_token      <= in_token_next;
      char_position <= char_position_next;
      header_good   <= header_good_next;
      negative_flag <= negative_flag_next;
      accumulator   <= accumulator_next;
      held_setpoint <= held_setpoint_next;
    end
  end

  // per-line axis values, undefined until written
  always_ff @(posedge clk) begin
    if (take) begin
      parsed_values <= parsed_values_next;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_result) begin
      res_valid <= 1'b1;
    end else if (res_pop) begin
      res_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load_result) begin
      res <= res_next;
    end
  end

endmodule

/* hdl/setpoint_command_parser_core.sv */
// ----------------------------------------------------------------------------
// setpoint_command_parser_core: setpoint command line parser
// Parses "<letter> <x> <y> <z>" lines one character at a time and holds
// the last accepted x/y/z setpoint.
//
//   channel   handshake              payload
//   input     push / full            char_in
//   result    empty / pop            status, x_moment, y_moment, z_moment
//   config    cfg_write              cfg_index, cfg_data
//
// One character per cycle sustained while full is low; a character enters the
// four-entry command queue on accept and the parser takes it from there
// once the queue shows it valid; a terminator's result is registered in the
// output register, from which it can then be popped.
// A terminator waits in the queue while the single output register is
// occupied; full rises once the queue has filled behind it.
// Synchronous reset clears the queue, parse state, held setpoint and
// configuration to its reset values; there is no clearing pass.
// ----------------------------------------------------------------------------
module setpoint_command_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [scp_pkg::CHAR_W-1:0]    char_in,
  output logic                          empty,
  input  logic                          pop,
  output logic                          status,
  output logic signed [scp_pkg::VAL_W-1:0] x_moment,
  output logic signed [scp_pkg::VAL_W-1:0] y_moment,
  output logic signed [scp_pkg::VAL_W-1:0] z_moment,
  input  logic                          cfg_write,
  input  logic [scp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scp_pkg::CHAR_W-1:0]    cfg_data
);

  scp_pkg::cfg_t    cfg;
  logic             q_write;
  scp_pkg::item_t   q_wr_item;
  logic             q_read;
  logic             q_valid;
  scp_pkg::item_t   q_rd_item;
  logic             res_valid;
  scp_pkg::result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator  <= scp_pkg::SEPARATOR_RESET;
      cfg.terminator <= scp_pkg::TERMINATOR_RESET;
      cfg.command    <= scp_pkg::COMMAND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        scp_pkg::REG_SEPARATOR:  cfg.separator  <= cfg_data;
        scp_pkg::REG_TERMINATOR: cfg.terminator <= cfg_data;
        scp_pkg::REG_COMMAND:    cfg.command    <= cfg_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // classifier
  scp_front u_front (
    .push    (push),
    .full    (full),
    .char_in (char_in),
    .cfg     (cfg),
    .q_write (q_write),
    .q_item  (q_wr_item)
  );

  // command queue
  scp_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_write),
    .wr_item  (q_wr_item),
    .full     (full),
    .rd       (q_read),
    .rd_valid (q_valid),
    .rd_item  (q_rd_item)
  );

  // parser and output register
  scp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .command   (cfg.command),
    .q_valid   (q_valid),
    .q_item    (q_rd_item),
    .q_read    (q_read),
    .res_pop   (pop && res_valid),
    .res_valid (res_valid),
    .res       (res)
  );

  // result ports
  assign empty    = !res_valid;
  assign status   = res.status;
  assign x_moment = res.moment[0];
  assign y_moment = res.moment[1];
  assign z_moment = res.moment[2];

endmodule
